// File: rtl/ffl_pkg.sv
package ffl_pkg;

	localparam int QUEUE_DEPTH  = 8;
	localparam int FLIGHT_DEPTH = 8;
	localparam int STAMP_BITS   = 32;

	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FIDX_W = (FLIGHT_DEPTH > 1) ? $clog2(FLIGHT_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FCNT_W = $clog2(FLIGHT_DEPTH + 1);
	localparam int DIFF_W = (STAMP_BITS > 32) ? STAMP_BITS : 32;

	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [QIDX_W-1:0]     qidx_t;
	typedef logic [FIDX_W-1:0]     fidx_t;
	typedef logic [QCNT_W-1:0]     qcnt_t;
	typedef logic [FCNT_W-1:0]     fcnt_t;

	typedef enum logic [1:0] {
		CFG_MAX_IN_FLIGHT     = 2'd0,
		CFG_MAX_IN_QUEUE      = 2'd1,
		CFG_IN_FLIGHT_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_FRAME  = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLIGHT_RD,
		ST_FLIGHT_CHK,
		ST_WAIT_RD,
		ST_WAIT_EMIT
	} state_t;

	typedef struct packed {
		logic        op;
		logic [31:0] stamp;
		logic [15:0] frame_tag;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_stamp;
		logic [15:0] out_tag;
		logic        allowed;
		logic        last;
	} out_item_t;

	// limits already saturated: in flight to its ring size, in queue to one below its ring size
	typedef struct packed {
		fcnt_t       flim;
		qcnt_t       qlim;
		logic [31:0] timeout;
	} cfg_t;

endpackage

// File: rtl/frame_flow_limiter_unit.sv
// flow: an accepted item is registered; a finished notice or a timed arrival then scans
// the flight ring from its head, retiring entries until one stays or the ring is empty;
// then each result is read at the wait ring head and emitted, held while output stalls;
// throughput: one item at a time, taken only in idle, set by the read-modify-write turn
// on the single-port wait and flight rings; reset clears counts and ring pointers
// at once, sets flight limit to 1, queue limit and timeout to 0; ring contents stay
module frame_flow_limiter_unit
	import ffl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg;

	ffl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// rings
	stamp_t      wait_stamp_mem [QUEUE_DEPTH];
	logic [15:0] wait_tag_mem   [QUEUE_DEPTH];
	stamp_t      flight_mem     [FLIGHT_DEPTH];

	stamp_t      wait_stamp_rd_q;
	logic [15:0] wait_tag_rd_q;
	stamp_t      flight_rd_q;

	state_t state_q, state_d;
	logic   op_q;
	stamp_t stamp_q;
	qidx_t  whead_q, wtail_q;
	fidx_t  fhead_q, ftail_q;
	qcnt_t  wcnt_q;
	fcnt_t  fcnt_q;
	logic   rel_q;
	logic   out_valid_q;
	out_item_t out_q;

	logic   accept;
	logic   wait_wr;
	logic   flight_rd;
	logic   flight_pop;
	logic   wait_rd;
	logic   rel_d;
	logic   emit;
	logic   emit_last;
	logic   slot_free;
	qcnt_t  wcnt_n;
	fcnt_t  fcnt_n;
	logic   retire_hit;
	stamp_t age;

	function automatic qidx_t qinc(qidx_t p);
		qinc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + qidx_t'(1);
	endfunction

	function automatic fidx_t finc(fidx_t p);
		finc = (int'(p) == FLIGHT_DEPTH - 1) ? '0 : p + fidx_t'(1);
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign age = stamp_q - flight_rd_q;

	always_comb begin
		if (op_q == OP_FINISH)
			retire_hit = (flight_rd_q <= stamp_q);
		else
			retire_hit = (stamp_q >= flight_rd_q) &&
				(DIFF_W'(age) > DIFF_W'(cfg.timeout));
	end

	// counts after the result now being emitted
	assign wcnt_n = wcnt_q - qcnt_t'(1);
	assign fcnt_n = rel_q ? fcnt_q + fcnt_t'(1) : fcnt_q;
	assign emit_last = !(((fcnt_n < cfg.flim) && (wcnt_n != '0)) || (wcnt_n > cfg.qlim));

	always_comb begin
		state_d    = state_q;
		wait_wr    = 1'b0;
		flight_rd  = 1'b0;
		flight_pop = 1'b0;
		wait_rd    = 1'b0;
		rel_d      = rel_q;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					wait_wr = (in_item.op == OP_FRAME) && (int'(wcnt_q) < QUEUE_DEPTH);
					if (in_item.op == OP_FINISH || cfg.timeout != '0)
						state_d = ST_FLIGHT_RD;
					else
						state_d = ST_WAIT_RD;
				end
			end
			ST_FLIGHT_RD: begin
				if (fcnt_q == '0) begin
					state_d = ST_WAIT_RD;
				end else begin
					flight_rd = 1'b1;
					state_d   = ST_FLIGHT_CHK;
				end
			end
			ST_FLIGHT_CHK: begin
				if (retire_hit) begin
					flight_pop = 1'b1;
					state_d    = ST_FLIGHT_RD;
				end else begin
					state_d = ST_WAIT_RD;
				end
			end
			ST_WAIT_RD: begin
				if ((fcnt_q < cfg.flim) && (wcnt_q != '0)) begin
					rel_d   = 1'b1;
					wait_rd = 1'b1;
					state_d = ST_WAIT_EMIT;
				end else if (wcnt_q > cfg.qlim) begin
					rel_d   = 1'b0;
					wait_rd = 1'b1;
					state_d = ST_WAIT_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WAIT_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = emit_last ? ST_IDLE : ST_WAIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			whead_q     <= '0;
			wtail_q     <= '0;
			wcnt_q      <= '0;
			fhead_q     <= '0;
			ftail_q     <= '0;
			fcnt_q      <= '0;
			rel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rel_q   <= rel_d;
			if (wait_wr) begin
				wtail_q <= qinc(wtail_q);
				wcnt_q  <= wcnt_q + qcnt_t'(1);
			end
			if (flight_pop) begin
				fhead_q <= finc(fhead_q);
				fcnt_q  <= fcnt_q - fcnt_t'(1);
			end
			if (emit) begin
				whead_q <= qinc(whead_q);
				wcnt_q  <= wcnt_n;
				if (rel_q) begin
					ftail_q <= finc(ftail_q);
					fcnt_q  <= fcnt_n;
				end
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_item.op;
			stamp_q <= stamp_t'(in_item.stamp);
		end
		if (emit) begin
			out_q.out_stamp <= 32'(wait_stamp_rd_q);
			out_q.out_tag   <= wait_tag_rd_q;
			out_q.allowed   <= rel_q;
			out_q.last      <= emit_last;
		end
	end

	// wait ring: written on arrival, read at the head for release or drop
	always_ff @(posedge clk) begin
		if (wait_wr) begin
			wait_stamp_mem[wtail_q] <= stamp_t'(in_item.stamp);
			wait_tag_mem[wtail_q]   <= in_item.frame_tag;
		end
		if (wait_rd) begin
			wait_stamp_rd_q <= wait_stamp_mem[whead_q];
			wait_tag_rd_q   <= wait_tag_mem[whead_q];
		end
	end

	// flight ring: written on release, read at the head for retire checks
	always_ff @(posedge clk) begin
		if (emit && rel_q)
			flight_mem[ftail_q] <= wait_stamp_rd_q;
		if (flight_rd)
			flight_rd_q <= flight_mem[fhead_q];
	end

endmodule

// File: rtl/ffl_cfg.sv
module ffl_cfg
	import ffl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic [3:0]  max_in_flight_q;
	logic [2:0]  max_in_queue_q;
	logic [31:0] timeout_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_in_flight_q <= 4'd1;
			max_in_queue_q  <= 3'd0;
			timeout_q       <= 32'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_IN_FLIGHT:     max_in_flight_q <= cfg_data[3:0];
				CFG_MAX_IN_QUEUE:      max_in_queue_q  <= cfg_data[2:0];
				CFG_IN_FLIGHT_TIMEOUT: timeout_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate so that an arrival always finds a free wait slot
	always_comb begin
		if (int'(max_in_flight_q) > FLIGHT_DEPTH)
			cfg.flim = FCNT_W'(FLIGHT_DEPTH);
		else
			cfg.flim = FCNT_W'(max_in_flight_q);
		if (int'(max_in_queue_q) > QUEUE_DEPTH - 1)
			cfg.qlim = QCNT_W'(QUEUE_DEPTH - 1);
		else
			cfg.qlim = QCNT_W'(max_in_queue_q);
		cfg.timeout = timeout_q;
	end

endmodule
